[hdl/bpd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package bpd_pkg;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [3:0] PH_LOAD_LO = 4'd0;
  localparam logic [3:0] PH_LOAD_HI = 4'd1;
  localparam logic [3:0] PH_LINK_LO = 4'd2;
  localparam logic [3:0] PH_LINK_HI = 4'd3;
  localparam logic [3:0] PH_NUM_LO  = 4'd4;
  localparam logic [3:0] PH_NUM_HI  = 4'd5;
  localparam logic [3:0] PH_BODY    = 4'd6;
  localparam logic [3:0] PH_FILL    = 4'd7;
  localparam logic [3:0] PH_HALT    = 4'd8;

  localparam logic [7:0] TOKEN_FIRST = 8'h80;
  localparam logic [7:0] TOKEN_LAST  = 8'hcb;
  localparam logic [7:0] QUOTE_CHAR  = 8'h22;

  localparam logic [2:0] K_LINENO = 3'd0;
  localparam logic [2:0] K_CHAR   = 3'd1;
  localparam logic [2:0] K_PLACE  = 3'd2;
  localparam logic [2:0] K_EOL    = 3'd3;
  localparam logic [2:0] K_END    = 3'd4;
  localparam logic [2:0] K_BADLNK = 3'd5;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] value;
    logic        kw;
    logic        pair;
  } op_t;

  typedef struct packed {
    logic [2:0]  len;
    logic [55:0] text;
  } kw_t;

  function automatic kw_t kw_entry(input logic [6:0] idx);
    kw_t e;
    e.len = 3'd1;
    e.text = '0;
    case (idx)
      7'd0:  begin e.len = 3'd3; e.text = 56'("END");     end
      7'd1:  begin e.len = 3'd3; e.text = 56'("FOR");     end
      7'd2:  begin e.len = 3'd4; e.text = 56'("NEXT");    end
      7'd3:  begin e.len = 3'd4; e.text = 56'("DATA");    end
      7'd4:  begin e.len = 3'd6; e.text = 56'("INPUT#");  end
      7'd5:  begin e.len = 3'd5; e.text = 56'("INPUT");   end
      7'd6:  begin e.len = 3'd3; e.text = 56'("DIM");     end
      7'd7:  begin e.len = 3'd4; e.text = 56'("READ");    end
      7'd8:  begin e.len = 3'd3; e.text = 56'("LET");     end
      7'd9:  begin e.len = 3'd4; e.text = 56'("GOTO");    end
      7'd10: begin e.len = 3'd3; e.text = 56'("RUN");     end
      7'd11: begin e.len = 3'd2; e.text = 56'("IF");      end
      7'd12: begin e.len = 3'd7; e.text = 56'("RESTORE"); end
      7'd13: begin e.len = 3'd5; e.text = 56'("GOSUB");   end
      7'd14: begin e.len = 3'd6; e.text = 56'("RETURN");  end
      7'd15: begin e.len = 3'd3; e.text = 56'("REM");     end
      7'd16: begin e.len = 3'd4; e.text = 56'("STOP");    end
      7'd17: begin e.len = 3'd2; e.text = 56'("ON");      end
      7'd18: begin e.len = 3'd4; e.text = 56'("WAIT");    end
      7'd19: begin e.len = 3'd4; e.text = 56'("LOAD");    end
      7'd20: begin e.len = 3'd4; e.text = 56'("SAVE");    end
      7'd21: begin e.len = 3'd6; e.text = 56'("VERIFY");  end
      7'd22: begin e.len = 3'd3; e.text = 56'("DEF");     end
      7'd23: begin e.len = 3'd4; e.text = 56'("POKE");    end
      7'd24: begin e.len = 3'd6; e.text = 56'("PRINT#");  end
      7'd25: begin e.len = 3'd5; e.text = 56'("PRINT");   end
      7'd26: begin e.len = 3'd4; e.text = 56'("CONT");    end
      7'd27: begin e.len = 3'd4; e.text = 56'("LIST");    end
      7'd28: begin e.len = 3'd3; e.text = 56'("CLR");     end
      7'd29: begin e.len = 3'd3; e.text = 56'("CMD");     end
      7'd30: begin e.len = 3'd3; e.text = 56'("SYS");     end
      7'd31: begin e.len = 3'd4; e.text = 56'("OPEN");    end
      7'd32: begin e.len = 3'd5; e.text = 56'("CLOSE");   end
      7'd33: begin e.len = 3'd3; e.text = 56'("GET");     end
      7'd34: begin e.len = 3'd3; e.text = 56'("NEW");     end
      7'd35: begin e.len = 3'd4; e.text = 56'("TAB(");    end
      7'd36: begin e.len = 3'd2; e.text = 56'("TO");      end
      7'd37: begin e.len = 3'd2; e.text = 56'("FN");      end
      7'd38: begin e.len = 3'd4; e.text = 56'("SPC(");    end
      7'd39: begin e.len = 3'd4; e.text = 56'("THEN");    end
      7'd40: begin e.len = 3'd3; e.text = 56'("NOT");     end
      7'd41: begin e.len = 3'd4; e.text = 56'("STEP");    end
      7'd42: begin e.len = 3'd1; e.text = 56'("+");       end
      7'd43: begin e.len = 3'd1; e.text = 56'("-");       end
      7'd44: begin e.len = 3'd1; e.text = 56'("*");       end
      7'd45: begin e.len = 3'd1; e.text = 56'("/");       end
      7'd46: begin e.len = 3'd1; e.text = 56'("^");       end
      7'd47: begin e.len = 3'd3; e.text = 56'("AND");     end
      7'd48: begin e.len = 3'd2; e.text = 56'("OR");      end
      7'd49: begin e.len = 3'd1; e.text = 56'(">");       end
      7'd50: begin e.len = 3'd1; e.text = 56'("=");       end
      7'd51: begin e.len = 3'd1; e.text = 56'("<");       end
      7'd52: begin e.len = 3'd3; e.text = 56'("SGN");     end
      7'd53: begin e.len = 3'd3; e.text = 56'("INT");     end
      7'd54: begin e.len = 3'd3; e.text = 56'("ABS");     end
      7'd55: begin e.len = 3'd3; e.text = 56'("USR");     end
      7'd56: begin e.len = 3'd3; e.text = 56'("FRE");     end
      7'd57: begin e.len = 3'd3; e.text = 56'("POS");     end
      7'd58: begin e.len = 3'd3; e.text = 56'("SQR");     end
      7'd59: begin e.len = 3'd3; e.text = 56'("RND");     end
      7'd60: begin e.len = 3'd3; e.text = 56'("LOG");     end
      7'd61: begin e.len = 3'd3; e.text = 56'("EXP");     end
      7'd62: begin e.len = 3'd3; e.text = 56'("COS");     end
      7'd63: begin e.len = 3'd3; e.text = 56'("SIN");     end
      7'd64: begin e.len = 3'd3; e.text = 56'("TAN");     end
      7'd65: begin e.len = 3'd3; e.text = 56'("ATN");     end
      7'd66: begin e.len = 3'd4; e.text = 56'("PEEK");    end
      7'd67: begin e.len = 3'd3; e.text = 56'("LEN");     end
      7'd68: begin e.len = 3'd4; e.text = 56'("STR$");    end
      7'd69: begin e.len = 3'd3; e.text = 56'("VAL");     end
      7'd70: begin e.len = 3'd3; e.text = 56'("ASC");     end
      7'd71: begin e.len = 3'd4; e.text = 56'("CHR$");    end
      7'd72: begin e.len = 3'd5; e.text = 56'("LEFT$");   end
      7'd73: begin e.len = 3'd6; e.text = 56'("RIGHT$");  end
      7'd74: begin e.len = 3'd4; e.text = 56'("MID$");    end
      7'd75: begin e.len = 3'd2; e.text = 56'("GO");      end
      default: begin e.len = 3'd1; e.text = '0;          end
    endcase
    return e;
  endfunction

endpackage

`default_nettype wire

[hdl/basic_program_detokenizer.sv]
// Streaming detokenizer for a tokenized BASIC V2 program file.
// Input channel: push/full. One file byte per transaction, with
// start_of_file set on the first byte of a file to restart parsing.
// Result channel: empty/pop. While empty is low, kind/value/last show the
// oldest result; a pop transaction removes it. last marks the final result
// caused by one input byte.
// Throughput: one byte per cycle at the input as long as the op queue has
// room; one result per cycle at the output while pop keeps up and ops are
// queued. A keyword token gives one result per character (up to seven),
// an end of line with a bad link gives two; the op queue between parser and
// expander absorbs these bursts. An accepted byte's op is written to the op
// queue; its first result then goes into the result register to be popped.
// Bytes that cause no result (load address, nonzero link, fill) still use a
// queue slot check but produce nothing.
// Reset: synchronous rst empties the queue and the result register and
// returns the parser to the load address low byte.
// When pop stays low, the result holds, the op queue fills and full rises.
`timescale 1ns / 1ps
`default_nettype none

module basic_program_detokenizer #(
  parameter int QUEUE_DEPTH = bpd_pkg::QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  file_byte,
  input  wire logic        start_of_file,
  output logic             empty,
  input  wire logic        pop,
  output logic [2:0]       kind,
  output logic [15:0]      value,
  output logic             last
);
  import bpd_pkg::*;

  op_t  f_op;
  op_t  b_op;
  logic f_push;
  logic q_empty;
  logic q_pop;

  bpd_front u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .file_byte     (file_byte),
    .start_of_file (start_of_file),
    .q_full        (full),
    .q_push        (f_push),
    .q_op          (f_op)
  );

  bpd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (f_push),
    .wr_op (f_op),
    .full  (full),
    .rd    (q_pop),
    .rd_op (b_op),
    .empty (q_empty)
  );

  bpd_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_op    (b_op),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .empty   (empty),
    .pop     (pop),
    .kind    (kind),
    .value   (value),
    .last    (last)
  );

endmodule

`default_nettype wire

[hdl/bpd_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module bpd_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire logic [7:0]    file_byte,
  input  wire logic          start_of_file,
  input  wire logic          q_full,
  output logic               q_push,
  output bpd_pkg::op_t       q_op
);
  import bpd_pkg::*;

  logic [3:0]  phase, phase_next;
  logic [7:0]  lo_byte, lo_byte_next;
  logic [15:0] next_link, next_link_next;
  logic [15:0] position, position_next;
  logic        in_quotes, in_quotes_next;
  logic [3:0]  ph;
  logic [15:0] pos_inc;
  logic [15:0] link_full;
  logic        act;

  assign act = push && !q_full;
  assign ph = start_of_file ? PH_LOAD_LO : phase;
  assign pos_inc = position + 16'd1;
  assign link_full = {file_byte, next_link[7:0]};

  always_comb begin
    phase_next = phase;
    lo_byte_next = lo_byte;
    next_link_next = next_link;
    position_next = position;
    in_quotes_next = start_of_file ? 1'b0 : in_quotes;
    q_push = 1'b0;
    q_op.kind = K_CHAR;
    q_op.value = {8'h00, file_byte};
    q_op.kw = 1'b0;
    q_op.pair = 1'b0;
    case (ph)
      PH_LOAD_LO: begin
        lo_byte_next = file_byte;
        phase_next = PH_LOAD_HI;
      end
      PH_LOAD_HI: begin
        position_next = {file_byte, lo_byte};
        phase_next = PH_LINK_LO;
      end
      PH_LINK_LO: begin
        position_next = pos_inc;
        next_link_next = {8'h00, file_byte};
        phase_next = PH_LINK_HI;
      end
      PH_LINK_HI: begin
        position_next = pos_inc;
        next_link_next = link_full;
        if (link_full == 16'd0) begin
          q_push = act;
          q_op.kind = K_END;
          q_op.value = 16'd0;
          phase_next = PH_HALT;
        end else begin
          phase_next = PH_NUM_LO;
        end
      end
      PH_NUM_LO: begin
        position_next = pos_inc;
        lo_byte_next = file_byte;
        phase_next = PH_NUM_HI;
      end
      PH_NUM_HI: begin
        position_next = pos_inc;
        q_push = act;
        q_op.kind = K_LINENO;
        q_op.value = {file_byte, lo_byte};
        in_quotes_next = 1'b0;
        phase_next = PH_BODY;
      end
      PH_BODY: begin
        position_next = pos_inc;
        q_push = act;
        if (file_byte == 8'h00) begin
          in_quotes_next = 1'b0;
          q_op.kind = K_EOL;
          q_op.value = next_link;
          if (next_link == pos_inc) begin
            phase_next = PH_LINK_LO;
          end else if (next_link > pos_inc) begin
            phase_next = PH_FILL;
          end else begin
            q_op.pair = 1'b1;
            phase_next = PH_HALT;
          end
        end else if (file_byte == QUOTE_CHAR) begin
          in_quotes_next = !in_quotes_next;
        end else if (!in_quotes_next && file_byte inside {[TOKEN_FIRST:TOKEN_LAST]}) begin
          q_op.kw = 1'b1;
          q_op.value = {8'h00, file_byte - TOKEN_FIRST};
        end else if (file_byte inside {[8'h20:8'h5b], 8'h5d, 8'h5e}) begin
          q_op.kind = K_CHAR;
        end else begin
          q_op.kind = K_PLACE;
        end
      end
      PH_FILL: begin
        position_next = pos_inc;
        if (pos_inc == next_link) begin
          phase_next = PH_LINK_LO;
        end
      end
      PH_HALT: begin
        phase_next = PH_HALT;
      end
      default: begin
        phase_next = PH_HALT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_LOAD_LO;
      in_quotes <= 1'b0;
      position <= 16'd0;
      next_link <= 16'd0;
    end else if (act) begin
      phase <= phase_next;
      in_quotes <= in_quotes_next;
      position <= position_next;
      next_link <= next_link_next;
    end
  end

  always_ff @(posedge clk) begin
    if (act) begin
      lo_byte <= lo_byte_next;
    end
  end

endmodule

`default_nettype wire

[hdl/bpd_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module bpd_queue #(
  parameter int DEPTH = bpd_pkg::QUEUE_DEPTH
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          wr,
  input  wire bpd_pkg::op_t  wr_op,
  output logic               full,
  input  wire logic          rd,
  output bpd_pkg::op_t       rd_op,
  output logic               empty
);
  import bpd_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  op_t           store [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [AW:0]   count;
  logic          do_wr, do_rd;

  assign full = count == (AW+1)'(DEPTH);
  assign empty = count == '0;
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rd_op = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + (AW+1)'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - (AW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      store[wr_ptr] <= wr_op;
    end
  end

endmodule

`default_nettype wire

[hdl/bpd_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module bpd_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire bpd_pkg::op_t  q_op,
  input  wire logic          q_empty,
  output logic               q_pop,
  output logic               empty,
  input  wire logic          pop,
  output logic [2:0]         kind,
  output logic [15:0]        value,
  output logic               last
);
  import bpd_pkg::*;

  logic        out_valid;
  logic [2:0]  sub;
  logic        advance;
  kw_t         entry;
  logic [2:0]  sel;
  logic [55:0] shifted;
  logic [2:0]  kind_next;
  logic [15:0] value_next;
  logic        last_next;

  assign empty = !out_valid;
  assign advance = !q_empty && (!out_valid || pop);
  assign entry = kw_entry(q_op.value[6:0]);
  assign sel = entry.len - 3'd1 - sub;
  assign shifted = entry.text >> {sel, 3'b000};

  always_comb begin
    if (q_op.kw) begin
      kind_next = K_CHAR;
      value_next = {8'h00, shifted[7:0]};
      last_next = sub == entry.len - 3'd1;
    end else if (q_op.pair) begin
      kind_next = (sub == 3'd0) ? K_EOL : K_BADLNK;
      value_next = (sub == 3'd0) ? 16'd0 : q_op.value;
      last_next = sub != 3'd0;
    end else begin
      kind_next = q_op.kind;
      value_next = (q_op.kind == K_EOL) ? 16'd0 : q_op.value;
      last_next = 1'b1;
    end
  end

  assign q_pop = advance && last_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sub <= 3'd0;
    end else if (advance) begin
      out_valid <= 1'b1;
      sub <= last_next ? 3'd0 : sub + 3'd1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      kind <= kind_next;
      value <= value_next;
      last <= last_next;
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");
  a_badlink_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && kind == K_BADLNK) |-> last)
    else $error("bad link result not final");
  a_eol_value: assert property (@(posedge clk) disable iff (rst)
    (!empty && (kind == K_EOL || kind == K_END)) |-> value == 16'd0)
    else $error("line or program end carries a value");
  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> kind <= K_BADLNK)
    else $error("result kind out of range");
  a_hold_sub: assert property (@(posedge clk) disable iff (rst)
    (q_empty && !$past(advance)) |-> $stable(sub))
    else $error("expansion index moved without work");

endmodule

`default_nettype wire
